>>> rtl/red_pkg.sv
package red_pkg;

    // Width of the position counter; results are sign-extended or cut to 16 bits.
    localparam int COUNT_WIDTH = 16;

    localparam int FIELD_WIDTH = 16;
    localparam int LOCK_WIDTH  = 16;

    localparam logic [LOCK_WIDTH-1:0] LOCK_START = LOCK_WIDTH'(65000);

    // Configuration register indexes
    localparam logic CFG_HALF_STEP = 1'b0;
    localparam logic CFG_SWITCH_EN = 1'b1;

    // Item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Last step direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    // Step flag in bits 5:4 of a table entry
    localparam logic [1:0] FLAG_NONE  = 2'b00;
    localparam logic [1:0] FLAG_RIGHT = 2'b01;

    localparam logic [2:0] FULL_STATES = 3'd7;
    localparam logic [2:0] HALF_STATES = 3'd6;

    typedef logic [5:0] entry_t;

    // Rows are states, columns are B*2+A. Low nibble next state, bits 5:4 step flag.
    localparam entry_t FULL_TABLE [0:6][0:3] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h10},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h20},
        '{6'h06, 6'h05, 6'h04, 6'h00}
    };

    localparam entry_t HALF_TABLE [0:5][0:3] = '{
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h23, 6'h00, 6'h01, 6'h00},
        '{6'h13, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h05, 6'h04, 6'h00},
        '{6'h03, 6'h03, 6'h04, 6'h10},
        '{6'h03, 6'h05, 6'h03, 6'h20}
    };

    typedef struct packed {
        logic                          command;
        logic                          line_a;
        logic                          line_b;
        logic                          switch_level;
        logic signed [FIELD_WIDTH-1:0] load_value;
    } item_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] position;
        logic                          step_event;
        logic [1:0]                    step_direction;
        logic                          press_event;
    } result_t;

    typedef struct packed {
        logic [2:0]                    table_state;
        logic signed [COUNT_WIDTH-1:0] position_count;
        logic [1:0]                    last_direction;
        logic [LOCK_WIDTH-1:0]         release_lock;
    } dec_state_t;

endpackage

>>> rtl/red_step.sv
// One decode step: table lookup, count update and switch lock for one item.
module red_step
(
    input  logic                  half_step_mode,
    input  logic                  switch_enable,
    input  red_pkg::item_t        item,
    input  red_pkg::dec_state_t   cur,
    output red_pkg::dec_state_t   nxt,
    output red_pkg::result_t      res
);

    logic [1:0]           ab;
    logic [2:0]           row;
    red_pkg::entry_t      entry;
    logic [1:0]           flag;
    logic                 step;
    logic                 press;

    assign ab = {item.line_b, item.line_a};

    // Rows past the end of the selected table read as state 0.
    always_comb
    begin
        row = cur.table_state;
        if (half_step_mode)
        begin
            if (cur.table_state >= red_pkg::HALF_STATES)
                row = 3'd0;
            entry = red_pkg::HALF_TABLE[row][ab];
        end
        else
        begin
            if (cur.table_state >= red_pkg::FULL_STATES)
                row = 3'd0;
            entry = red_pkg::FULL_TABLE[row][ab];
        end
    end

    assign flag = entry[5:4];

    always_comb
    begin
        nxt   = cur;
        step  = 1'b0;
        press = 1'b0;
        if (item.command == red_pkg::CMD_LOAD)
        begin
            nxt.position_count = red_pkg::COUNT_WIDTH'(item.load_value);
        end
        else
        begin
            nxt.table_state = entry[2:0];
            if (flag != red_pkg::FLAG_NONE)
            begin
                step = 1'b1;
                if (flag == red_pkg::FLAG_RIGHT)
                begin
                    nxt.last_direction = red_pkg::DIR_RIGHT;
                    nxt.position_count = cur.position_count + red_pkg::COUNT_WIDTH'(1);
                end
                else
                begin
                    nxt.last_direction = red_pkg::DIR_LEFT;
                    nxt.position_count = cur.position_count - red_pkg::COUNT_WIDTH'(1);
                end
            end
            if (switch_enable)
            begin
                if (cur.release_lock == '0 && !item.switch_level)
                begin
                    nxt.release_lock = red_pkg::LOCK_START;
                    press            = 1'b1;
                end
                else if (cur.release_lock != '0 && item.switch_level)
                begin
                    // hold counts up on released samples and unlocks on wrap
                    nxt.release_lock = cur.release_lock + red_pkg::LOCK_WIDTH'(1);
                end
            end
        end
    end

    assign res.position       = red_pkg::FIELD_WIDTH'(nxt.position_count);
    assign res.step_event     = step;
    assign res.step_direction = nxt.last_direction;
    assign res.press_event    = press;

endmodule

>>> rtl/rotary_encoder_decoder.sv
// Rotary encoder decoder. Each request on the slave stream is either a pin
// sample (tuser = 0: A, B and the active-low push switch) or a load of the
// position count (tuser = 1, load value in tdata). A sample walks a fixed
// transition table, full-step (7 states) or half-step (6 states) as chosen
// by cfg register 0; a completed detent bumps the signed position up (right)
// or down (left), wrapping. A switch press gives one press_event, after
// which the switch is locked until a release hold, started at 65000 and
// counted up per released sample, wraps to zero (cfg register 1 enables
// the switch). Every request gives exactly one result request on the master
// stream at one request per clock while m_axis_tready is high, through the
// input register, then the result register. The table lookup, the count
// adder and the lock incrementer all sit in the single stage between those
// two registers, and its state feedback sets the rate. s_axis_tready drops
// only while both registers are full and m_axis_tready is low. Configuration
// must be written while the stream is idle (not enforced); no read-back.
module rotary_encoder_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] line_a, [1] line_b, [2] switch_level, [18:3] load_value, [23:19] zero
    input  logic [23:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] position, [16] step_event, [18:17] step_direction,
    // [19] press_event, [23:20] zero
    output logic [23:0] m_axis_tdata
);

    // configuration
    logic half_step_reg;
    logic switch_en_reg;

    // input register
    logic                in_valid_reg;
    red_pkg::item_t      in_item_reg;

    // result register
    logic                out_valid_reg;
    red_pkg::result_t    out_res_reg;

    // decoder state, updated as each request moves into the result register
    red_pkg::dec_state_t state_reg;
    red_pkg::dec_state_t state_next;
    red_pkg::result_t    res_next;

    logic                advance;
    red_pkg::item_t      s_item;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign s_item.command      = s_axis_tuser;
    assign s_item.line_a       = s_axis_tdata[0];
    assign s_item.line_b       = s_axis_tdata[1];
    assign s_item.switch_level = s_axis_tdata[2];
    assign s_item.load_value   = s_axis_tdata[18:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_step_reg <= 1'b0;
            switch_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                red_pkg::CFG_HALF_STEP: half_step_reg <= cfg_data;
                red_pkg::CFG_SWITCH_EN: switch_en_reg <= cfg_data;
                default:                half_step_reg <= half_step_reg;
            endcase
        end
    end

    red_step u_step
    (
        .half_step_mode (half_step_reg),
        .switch_enable  (switch_en_reg),
        .item           (in_item_reg),
        .cur            (state_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= s_item;
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.press_event, out_res_reg.step_direction,
                            out_res_reg.step_event, out_res_reg.position};

`ifndef ASSERT_OFF
    // back-pressure reaches the slave side only when both stages are full
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("s_axis_tready low with a free stage");

    // a reported step always carries a direction
    a_step_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.step_event) |->
            (out_res_reg.step_direction != red_pkg::DIR_NONE))
        else $error("step event without a direction");

    // an accepted press arms the release lock
    a_press_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.press_event) |=> (state_reg.release_lock == red_pkg::LOCK_START))
        else $error("press accepted but lock not armed");

    // table walk never lands on the unused state
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.table_state != 3'd7)
        else $error("table state out of range");
`endif

endmodule

>>> tb/sv/testbench.sv
module testbench;

    // Cycles with no handshake on either stream before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // Pipeline: input then result register; extra wait before a cfg write or the end
    localparam int SETTLE_CYCLES = 4;
    // Released samples that take the lock from 65001 through the wrap to zero
    localparam int UNLOCK_SAMPLES = 535;

    // Detent tables, rows are states, columns are B*2+A.
    // Low bits next state, bits 5:4 step flag (01 right, 10 left).
    localparam logic [0:6][0:3][5:0] FULL_ROWS = {
        6'h00, 6'h02, 6'h04, 6'h00,
        6'h03, 6'h00, 6'h01, 6'h10,
        6'h03, 6'h02, 6'h00, 6'h00,
        6'h03, 6'h02, 6'h01, 6'h00,
        6'h06, 6'h00, 6'h04, 6'h00,
        6'h06, 6'h05, 6'h00, 6'h20,
        6'h06, 6'h05, 6'h04, 6'h00
    };
    localparam logic [0:5][0:3][5:0] HALF_ROWS = {
        6'h03, 6'h02, 6'h01, 6'h00,
        6'h23, 6'h00, 6'h01, 6'h00,
        6'h13, 6'h02, 6'h00, 6'h00,
        6'h03, 6'h05, 6'h04, 6'h00,
        6'h03, 6'h03, 6'h04, 6'h10,
        6'h03, 6'h05, 6'h03, 6'h20
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic        cfg_index = red_pkg::CFG_HALF_STEP;
    logic        cfg_data = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] line_a, [1] line_b, [2] switch_level, [18:3] load_value, [23:19] zero
    logic [23:0] s_axis_tdata = '0;
    // [0] command
    logic        s_axis_tuser = red_pkg::CMD_SAMPLE;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // [15:0] position, [16] step_event, [18:17] step_direction,
    // [19] press_event, [23:20] zero
    logic [23:0] m_axis_tdata;

    rotary_encoder_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Decoder model: mirrors the block's state, updated per accepted request
    // ---------------------------------------------------------------------
    logic        half_mode   = 1'b0;
    logic        switch_on   = 1'b1;
    logic [2:0]  detent_row  = '0;
    logic [15:0] count_now   = '0;
    logic [1:0]  last_turn   = red_pkg::DIR_NONE;
    logic [15:0] hold_count  = '0;      // zero = switch unlocked

    red_pkg::result_t expected_turns [$];   // one per accepted request, oldest first
    int          errors = 0;
    int          quiet_cycles = 0;

    // Stimulus knobs, percent per cycle
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // Encoder position in gray order; stepping pos down is a right turn
    logic [1:0]  enc_pos = 2'd0;
    int          walk_dir = 1;

    function automatic red_pkg::result_t predict_turn(red_pkg::item_t req);
        red_pkg::result_t res;
        logic [5:0]       entry;
        logic [2:0]       row;
        logic [1:0]       ab;
        res.step_event = 1'b0;
        res.press_event = 1'b0;
        if (req.command == red_pkg::CMD_LOAD)
        begin
            count_now = req.load_value;
        end
        else
        begin
            ab = {req.line_b, req.line_a};
            row = detent_row;
            // a state with no row in the current table (after a mode change) reads as 0
            if (half_mode)
            begin
                if (row >= 3'd6)
                    row = 3'd0;
                entry = HALF_ROWS[row][ab];
            end
            else
            begin
                if (row >= 3'd7)
                    row = 3'd0;
                entry = FULL_ROWS[row][ab];
            end
            detent_row = entry[2:0];
            if (entry[5:4] != red_pkg::FLAG_NONE)
            begin
                res.step_event = 1'b1;
                if (entry[5:4] == red_pkg::FLAG_RIGHT)
                begin
                    last_turn = red_pkg::DIR_RIGHT;
                    count_now = count_now + 16'd1;
                end
                else
                begin
                    last_turn = red_pkg::DIR_LEFT;
                    count_now = count_now - 16'd1;
                end
            end
            // press fires once, then the lock counts up on released samples until it wraps
            if (switch_on)
            begin
                if (hold_count == '0 && !req.switch_level)
                begin
                    hold_count = red_pkg::LOCK_START;
                    res.press_event = 1'b1;
                end
                else if (hold_count != '0 && req.switch_level)
                begin
                    hold_count = hold_count + 16'd1;
                end
            end
        end
        res.position = count_now;
        res.step_direction = last_turn;
        return res;
    endfunction

    // Accepted input requests feed the model
    always @(posedge clk)
    begin
        red_pkg::item_t req;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            req.command = s_axis_tuser;
            req.line_a = s_axis_tdata[0];
            req.line_b = s_axis_tdata[1];
            req.switch_level = s_axis_tdata[2];
            req.load_value = s_axis_tdata[18:3];
            expected_turns.push_back(predict_turn(req));
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Result stream checker
    always @(posedge clk)
    begin
        red_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_turns.size() == 0)
            begin
                errors++;
                $error("result request with nothing expected: tdata %h", m_axis_tdata);
            end
            else
            begin
                want = expected_turns.pop_front();
                check_field("position", int'(want.position),
                            int'($signed(m_axis_tdata[15:0])));
                check_field("step_event", int'(want.step_event), int'(m_axis_tdata[16]));
                check_field("step_direction", int'(want.step_direction),
                            int'(m_axis_tdata[18:17]));
                check_field("press_event", int'(want.press_event), int'(m_axis_tdata[19]));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: counts cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // One request; valid stays high across back-to-back requests
    task automatic send_request(logic cmd, logic a, logic b, logic sw, logic [15:0] load);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'b0, load, sw, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_sample(logic [1:0] ab, logic sw);
        send_request(red_pkg::CMD_SAMPLE, ab[0], ab[1], sw, 16'($urandom));
    endtask

    task automatic send_load(logic [15:0] value);
        send_request(red_pkg::CMD_LOAD, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), value);
    endtask

    function automatic logic [1:0] pin_code(logic [1:0] pos);
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // dir +1 turns right, -1 left
    task automatic step_encoder(int dir, logic sw);
        enc_pos = enc_pos - 2'(dir);
        send_sample(pin_code(enc_pos), sw);
    endtask

    // Stop sending and wait out every outstanding result plus pipeline slack
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_turns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == red_pkg::CFG_HALF_STEP)
            half_mode = value;
        else
            switch_on = value;
    endtask

    // Mostly clean rotation with reversals, plus loads and jumps on the pins
    task automatic run_random(int count, int press_pct);
        int          pick;
        logic        released;
        logic [15:0] value;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            released = ($urandom_range(99) >= press_pct);
            if (pick < 6)
            begin
                case ($urandom_range(3))
                    0: value = 16'h7FFF;
                    1: value = 16'h8000;
                    default: value = 16'($urandom);
                endcase
                send_load(value);
            end
            else if (pick < 14)
            begin
                enc_pos = 2'($urandom_range(3));
                send_sample(pin_code(enc_pos), released);
            end
            else
            begin
                if ($urandom_range(99) < 15)
                    walk_dir = -walk_dir;
                step_encoder(walk_dir, released);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Full-step turns across both ends of the count, and a load mid-detent
    task automatic test_full_step_wrap();
        enc_pos = 2'd2;                     // park at A=B=1
        send_sample(pin_code(enc_pos), 1'b1);
        send_load(16'h7FFF);
        repeat (4) step_encoder(1, 1'b1);   // right detent wraps to -32768
        send_load(16'h8000);
        repeat (4) step_encoder(-1, 1'b1);  // left detent wraps to 32767
        repeat (2) step_encoder(1, 1'b1);
        send_load(16'h1234);                // table state must survive the load
        repeat (2) step_encoder(1, 1'b1);
    endtask

    // Switch tables while the full-step walk sits in state 6
    task automatic test_mode_switch();
        repeat (2) step_encoder(-1, 1'b1);
        write_reg(red_pkg::CFG_HALF_STEP, 1'b1);
        send_sample(pin_code(enc_pos), 1'b1);   // state 6 has no half-step row
        repeat (4) step_encoder(-1, 1'b1);
        repeat (3) step_encoder(1, 1'b1);
        write_reg(red_pkg::CFG_HALF_STEP, 1'b0);
        repeat (2) step_encoder(1, 1'b1);
    endtask

    // Press, locked press, disabled switch, then hold release until the lock wraps
    task automatic test_push_switch();
        send_sample(pin_code(enc_pos), 1'b0);   // press event
        send_sample(pin_code(enc_pos), 1'b0);   // pressed while locked
        send_sample(pin_code(enc_pos), 1'b1);
        write_reg(red_pkg::CFG_SWITCH_EN, 1'b0);
        send_sample(pin_code(enc_pos), 1'b0);   // ignored
        send_sample(pin_code(enc_pos), 1'b1);
        write_reg(red_pkg::CFG_SWITCH_EN, 1'b1);
        send_sample(pin_code(enc_pos), 1'b0);   // still locked
        send_idle_pct = 22;
        stall_pct = 22;
        // every one of these is a released sample, so the lock counts 65001 up through the wrap
        for (int k = 0; k < UNLOCK_SAMPLES; k++)
        begin
            if ($urandom_range(99) < 15)
                walk_dir = -walk_dir;
            step_encoder(walk_dir, 1'b1);
        end
        send_sample(pin_code(enc_pos), 1'b0);   // unlocked again
    endtask

    // Random traffic under each idle/stall mix, stepping through the settings
    task automatic test_random_phases();
        int idle_mix [4] = '{0, 52, 0, 22};
        int stall_mix [4] = '{0, 0, 52, 22};
        for (int p = 0; p < 4; p++)
        begin
            write_reg(red_pkg::CFG_HALF_STEP, 1'(p % 2));
            write_reg(red_pkg::CFG_SWITCH_EN, (p != 2));
            send_idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            run_random(35, 4);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_full_step_wrap();
        test_mode_switch();
        test_push_switch();
        test_random_phases();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
